// ===== rtl/alids_pkg.sv =====
// shared types, codes and sizes for the array list block
// no dependencies
`default_nettype none
package alids_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int OP_W      = 3;
	localparam int POS_W     = 7;
	localparam int VAL_W     = 32;
	localparam int ST_W      = 3;
	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;

	typedef logic [OP_W-1:0]         opcode_t;
	typedef logic [POS_W-1:0]        pos_t;
	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [ST_W-1:0]         status_t;
	typedef logic [IDX_W-1:0]        index_t;
	typedef logic [CNT_W-1:0]        count_t;

	localparam opcode_t OP_CLEAR  = 3'd0;
	localparam opcode_t OP_APPEND = 3'd1;
	localparam opcode_t OP_INSERT = 3'd2;
	localparam opcode_t OP_DELETE = 3'd3;
	localparam opcode_t OP_SEARCH = 3'd4;
	localparam opcode_t OP_DUMP   = 3'd5;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_INVALID  = 3'd1;
	localparam status_t ST_FULL     = 3'd2;
	localparam status_t ST_NOTFOUND = 3'd3;
	localparam status_t ST_EMPTY    = 3'd4;

	typedef struct packed {
		opcode_t opcode;
		pos_t    position;
		value_t  item_value;
	} cmd_t;

	typedef struct packed {
		status_t status;
		index_t  index;
		value_t  entry_value;
		count_t  count;
		logic    last;
	} rsp_t;

endpackage
`default_nettype wire

// ===== rtl/alids_ram.sv =====
// entry store: one write port, one read port, registered read data
// depends on alids_pkg
`default_nettype none
module alids_ram #(
	parameter int DEPTH = alids_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire alids_pkg::value_t wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output alids_pkg::value_t      rdata
);

	alids_pkg::value_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/alids_ctrl.sv =====
// sequencer: decodes a request, walks the entry store, builds results
// depends on alids_pkg, drives alids_ram
`default_nettype none
module alids_ctrl #(
	parameter int DEPTH = alids_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire alids_pkg::cmd_t   cmd,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output alids_pkg::rsp_t        res,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output alids_pkg::value_t      mem_wdata,
	output logic                   mem_re,
	output logic [AW-1:0]          mem_raddr,
	input  wire alids_pkg::value_t mem_rdata
);

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cnt_t;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SHIFT  = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_DUMP   = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;

	logic [2:0]          state_q;
	cnt_t                count_q;
	alids_pkg::opcode_t  op_q;
	addr_t               pos_q;
	alids_pkg::value_t   val_q;
	addr_t               cur_q;
	cnt_t                rem_q;
	alids_pkg::status_t  status_q;
	addr_t               index_q;
	logic                pend_s1;
	addr_t               idx_s1;
	logic                last_s1;

	alids_pkg::pos_t     cnt_pos;
	logic                full;
	logic                issue;
	logic                hit;
	logic                up;

	assign cnt_pos = alids_pkg::pos_t'(count_q);
	assign full    = (count_q == cnt_t'(DEPTH));
	assign hit     = pend_s1 && (mem_rdata == val_q);
	assign up      = (op_q == alids_pkg::OP_INSERT);

	always_comb begin
		cmd_ready = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = cur_q;
		issue     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && cmd.opcode == alids_pkg::OP_APPEND && !full) begin
					mem_we    = 1'b1;
					mem_waddr = addr_t'(count_q);
					mem_wdata = cmd.item_value;
				end
			end
			S_SHIFT: begin
				issue  = (rem_q != '0);
				mem_re = issue;
				if (pend_s1) begin
					mem_we = 1'b1;
				end else if (!issue && up) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = val_q;
				end
			end
			S_SEARCH: begin
				issue  = (rem_q != '0) && !hit;
				mem_re = issue;
			end
			S_DUMP: begin
				issue             = (rem_q != '0) && (!pend_s1 || res_ready);
				mem_re            = issue;
				res_valid         = pend_s1;
				res.status        = alids_pkg::ST_OK;
				res.index         = alids_pkg::index_t'(idx_s1);
				res.entry_value   = mem_rdata;
				res.count         = alids_pkg::count_t'(count_q);
				res.last          = last_s1;
			end
			S_RESP: begin
				res_valid   = 1'b1;
				res.status  = status_q;
				res.index   = alids_pkg::index_t'(index_q);
				res.count   = alids_pkg::count_t'(count_q);
				res.last    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			pend_s1  <= 1'b0;
			op_q     <= alids_pkg::OP_CLEAR;
			pos_q    <= '0;
			val_q    <= '0;
			cur_q    <= '0;
			rem_q    <= '0;
			status_q <= alids_pkg::ST_OK;
			index_q  <= '0;
			idx_s1   <= '0;
			last_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (cmd_valid) begin
						op_q     <= cmd.opcode;
						pos_q    <= addr_t'(cmd.position);
						val_q    <= cmd.item_value;
						index_q  <= '0;
						status_q <= alids_pkg::ST_OK;
						unique case (cmd.opcode)
							alids_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_RESP;
							end
							alids_pkg::OP_APPEND: begin
								if (full) begin
									status_q <= alids_pkg::ST_FULL;
								end else begin
									count_q <= count_q + cnt_t'(1);
								end
								state_q <= S_RESP;
							end
							alids_pkg::OP_INSERT: begin
								if (cmd.position > cnt_pos) begin
									status_q <= alids_pkg::ST_INVALID;
									state_q  <= S_RESP;
								end else if (full) begin
									status_q <= alids_pkg::ST_FULL;
									state_q  <= S_RESP;
								end else begin
									cur_q   <= addr_t'(count_q - cnt_t'(1));
									rem_q   <= cnt_t'(cnt_pos - cmd.position);
									state_q <= S_SHIFT;
								end
							end
							alids_pkg::OP_DELETE: begin
								if (cmd.position >= cnt_pos) begin
									status_q <= alids_pkg::ST_INVALID;
									state_q  <= S_RESP;
								end else begin
									cur_q   <= addr_t'(cmd.position) + addr_t'(1);
									rem_q   <= cnt_t'(cnt_pos - cmd.position
										- alids_pkg::pos_t'(1));
									state_q <= S_SHIFT;
								end
							end
							alids_pkg::OP_SEARCH: begin
								cur_q   <= '0;
								rem_q   <= count_q;
								state_q <= S_SEARCH;
							end
							alids_pkg::OP_DUMP: begin
								if (count_q == '0) begin
									status_q <= alids_pkg::ST_EMPTY;
									state_q  <= S_RESP;
								end else begin
									cur_q   <= '0;
									rem_q   <= count_q;
									state_q <= S_DUMP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					pend_s1 <= issue;
					idx_s1  <= up ? (cur_q + addr_t'(1)) : (cur_q - addr_t'(1));
					if (issue) begin
						cur_q <= up ? (cur_q - addr_t'(1)) : (cur_q + addr_t'(1));
						rem_q <= rem_q - cnt_t'(1);
					end
					if (!pend_s1 && !issue) begin
						count_q <= up ? (count_q + cnt_t'(1)) : (count_q - cnt_t'(1));
						state_q <= S_RESP;
					end
				end
				S_SEARCH: begin
					pend_s1 <= issue;
					idx_s1  <= cur_q;
					if (issue) begin
						cur_q <= cur_q + addr_t'(1);
						rem_q <= rem_q - cnt_t'(1);
					end
					if (hit) begin
						index_q <= idx_s1;
						state_q <= S_RESP;
					end else if (!pend_s1 && rem_q == '0) begin
						status_q <= alids_pkg::ST_NOTFOUND;
						state_q  <= S_RESP;
					end
				end
				S_DUMP: begin
					if (!pend_s1 || res_ready) begin
						pend_s1 <= issue;
						idx_s1  <= cur_q;
						last_s1 <= (rem_q == cnt_t'(1));
						if (issue) begin
							cur_q <= cur_q + addr_t'(1);
							rem_q <= rem_q - cnt_t'(1);
						end
					end
					if (pend_s1 && res_ready && last_s1) begin
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/array_list_insert_delete_search.sv =====
// top level of the array list: sequencer, entry store and result register
// depends on alids_pkg, alids_ram, alids_ctrl
//
// channel | handshake            | payload
// --------+----------------------+-----------------------------------------
// cmd     | cmd_valid, cmd_ready | opcode, position, item_value
// rsp     | rsp_valid, rsp_ready | status, index, entry_value, count, last
//
// clear, append and rejected requests go straight to the response state
// insert and delete shift the tail of the list through the store,
// one entry moved per cycle; search reads until the first match or the end
// dump reads every entry, one result a cycle unless the result register is held
// reset clears the fill count and handshakes; stored entries are not cleared
// rsp_ready low holds the result register and pauses the dump reads
`default_nettype none
module array_list_insert_delete_search #(
	parameter int DEPTH = alids_pkg::DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_ready,
	input  wire alids_pkg::cmd_t cmd,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output alids_pkg::rsp_t      rsp
);

	localparam int AW = $clog2(DEPTH);

	logic              res_valid;
	logic              res_ready;
	alids_pkg::rsp_t   res;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	alids_pkg::value_t mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	alids_pkg::value_t mem_rdata;
	logic              rsp_valid_q;
	alids_pkg::rsp_t   rsp_q;

	alids_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	alids_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.count <= alids_pkg::count_t'(DEPTH)))
		else $error("fill count above depth");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> !res_valid)
		else $error("result offered while taking a request");

	a_only_dump_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (rsp.status == alids_pkg::ST_OK))
		else $error("non-final result with error status");

	a_error_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != alids_pkg::ST_OK) |-> (res.entry_value == '0))
		else $error("error result carries an entry value");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench for array_list_insert_delete_search: directed table, fill to full, random requests
// results are checked against an in-bench list model or the table's expected result, field by field, in order
// depends on alids_pkg and the array_list_insert_delete_search rtl
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import alids_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int RANDOM_REQUESTS = 100;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		cmd_t req;
		bit   typed;
		rsp_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	value_t list_mem [DEPTH];
	int     list_len = 0;
	rsp_t   predicted [$];
	rsp_t   expected_rsp [$];
	step_t  plan [$];
	int     mismatches = 0;
	bit     tx_idle = 1'b1;
	bit     rx_idle = 1'b1;
	rsp_t   head;

	array_list_insert_delete_search #(.DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#8_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic rsp_t result_of(status_t st, int idx, value_t v, bit lst);
		rsp_t r;
		r.status      = st;
		r.index       = index_t'(idx);
		r.entry_value = v;
		r.count       = count_t'(list_len);
		r.last        = lst;
		return r;
	endfunction

	// list model: updates the stored entries and fills predicted
	function automatic void list_apply(cmd_t c);
		int  p;
		int  i;
		bit  hit;
		p = int'(c.position);
		hit = 1'b0;
		predicted.delete();
		case (c.opcode)
			OP_CLEAR: begin
				list_len = 0;
				predicted.push_back(result_of(ST_OK, 0, '0, 1'b1));
			end
			OP_APPEND: begin
				if (list_len >= DEPTH) begin
					predicted.push_back(result_of(ST_FULL, 0, '0, 1'b1));
				end else begin
					list_mem[list_len] = c.item_value;
					list_len++;
					predicted.push_back(result_of(ST_OK, 0, '0, 1'b1));
				end
			end
			OP_INSERT: begin
				if (p > list_len) begin
					predicted.push_back(result_of(ST_INVALID, 0, '0, 1'b1));
				end else if (list_len >= DEPTH) begin
					predicted.push_back(result_of(ST_FULL, 0, '0, 1'b1));
				end else begin
					for (i = list_len; i > p; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p] = c.item_value;
					list_len++;
					predicted.push_back(result_of(ST_OK, 0, '0, 1'b1));
				end
			end
			OP_DELETE: begin
				if (p >= list_len) begin
					predicted.push_back(result_of(ST_INVALID, 0, '0, 1'b1));
				end else begin
					for (i = p; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
					predicted.push_back(result_of(ST_OK, 0, '0, 1'b1));
				end
			end
			OP_SEARCH: begin
				for (i = 0; i < list_len && !hit; i++) begin
					if (list_mem[i] == c.item_value) begin
						predicted.push_back(result_of(ST_OK, i, '0, 1'b1));
						hit = 1'b1;
					end
				end
				if (!hit)
					predicted.push_back(result_of(ST_NOTFOUND, 0, '0, 1'b1));
			end
			OP_DUMP: begin
				if (list_len == 0) begin
					predicted.push_back(result_of(ST_EMPTY, 0, '0, 1'b1));
				end else begin
					for (i = 0; i < list_len; i++)
						predicted.push_back(result_of(ST_OK, i, list_mem[i],
							i == list_len - 1));
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic step_t row(opcode_t op, int pos, logic [31:0] v, bit typed = 1'b0,
			status_t st = ST_OK, int cnt = 0, bit lst = 1'b1);
		step_t s;
		s.req.opcode     = op;
		s.req.position   = pos_t'(pos);
		s.req.item_value = value_t'(v);
		s.typed              = typed;
		s.want.status        = st;
		s.want.index         = '0;
		s.want.entry_value   = '0;
		s.want.count         = count_t'(cnt);
		s.want.last          = lst;
		return s;
	endfunction

	function automatic cmd_t make_req(opcode_t op, int pos, logic [31:0] v);
		cmd_t c;
		c.opcode     = op;
		c.position   = pos_t'(pos);
		c.item_value = value_t'(v);
		return c;
	endfunction

	task automatic send_request(cmd_t c, bit typed = 1'b0, rsp_t want = '0);
		if (tx_idle && $urandom_range(99) < 14) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 30);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		list_apply(c);
		if (typed)
			expected_rsp.push_back(want);
		else
			foreach (predicted[k])
				expected_rsp.push_back(predicted[k]);
	endtask

	// sender holds off until every outstanding result is back
	task automatic drain;
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic cmd_t random_req();
		int     r;
		int     pos;
		value_t v;
		opcode_t op;
		r = $urandom_range(99);
		v = ($urandom_range(3) == 0) ? value_t'($urandom_range(7)) - 4 : value_t'($urandom);
		pos = 0;
		if (r < 4) begin
			op = opcode_t'($urandom_range(7, 6));
			pos = $urandom_range(127);
		end else if (r < 7) begin
			op = OP_CLEAR;
		end else if (r < 35) begin
			op = OP_APPEND;
		end else if (r < 55) begin
			op = OP_INSERT;
			if ($urandom_range(99) < 85)
				pos = $urandom_range(list_len);
			else
				pos = $urandom_range(127, list_len + 1);
		end else if (r < 72) begin
			op = OP_DELETE;
			if (list_len > 0 && $urandom_range(99) < 85)
				pos = $urandom_range(list_len - 1);
			else
				pos = $urandom_range(127, list_len);
		end else if (r < 90) begin
			op = OP_SEARCH;
			if (list_len > 0 && $urandom_range(99) < 60)
				v = list_mem[$urandom_range(list_len - 1)];
		end else begin
			op = OP_DUMP;
		end
		return make_req(op, pos, v);
	endfunction

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: st=%0d idx=%0d val=%0d cnt=%0d last=%0d",
						rsp.status, rsp.index, rsp.entry_value, rsp.count, rsp.last);
			end else begin
				head = expected_rsp.pop_front();
				if (rsp.status !== head.status || rsp.index !== head.index ||
						rsp.entry_value !== head.entry_value || rsp.count !== head.count ||
						rsp.last !== head.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"mismatch: want st=%0d idx=%0d val=%0d cnt=%0d last=%0d,",
							" got st=%0d idx=%0d val=%0d cnt=%0d last=%0d"},
							head.status, head.index, head.entry_value, head.count,
							head.last, rsp.status, rsp.index, rsp.entry_value,
							rsp.count, rsp.last);
				end
			end
		end
		rsp_ready <= !(rx_idle && $urandom_range(99) < 14);
	end

	initial begin
		int n;
		int i;
		cmd_t c;

		plan.push_back(row(OP_DUMP,     0, 32'h0, 1'b1, ST_EMPTY, 0));
		plan.push_back(row(OP_SEARCH,   0, 32'h0, 1'b1, ST_NOTFOUND, 0));
		plan.push_back(row(OP_DELETE,   0, 32'h0, 1'b1, ST_INVALID, 0));
		plan.push_back(row(OP_INSERT,   1, 32'h7, 1'b1, ST_INVALID, 0));
		plan.push_back(row(OP_INSERT, 127, 32'h5, 1'b1, ST_INVALID, 0));
		plan.push_back(row(opcode_t'(6), 64, 32'hffffffff));
		plan.push_back(row(opcode_t'(7), 127, 32'h12345678));
		plan.push_back(row(OP_APPEND,   0, 32'h7fffffff, 1'b1, ST_OK, 1));
		plan.push_back(row(OP_APPEND, 127, 32'h80000000, 1'b1, ST_OK, 2));
		plan.push_back(row(OP_INSERT,   0, 32'hffffffff));
		plan.push_back(row(OP_INSERT,   3, 32'h0));
		plan.push_back(row(OP_INSERT,   2, 32'd12345));
		plan.push_back(row(OP_SEARCH,   0, 32'h80000000));
		plan.push_back(row(OP_SEARCH,   0, 32'hffffffff));
		plan.push_back(row(OP_SEARCH,   0, 32'd42, 1'b1, ST_NOTFOUND, 5));
		plan.push_back(row(OP_DUMP,     0, 32'h0));
		plan.push_back(row(OP_DELETE,   5, 32'h0, 1'b1, ST_INVALID, 5));
		plan.push_back(row(OP_DELETE,  64, 32'h0, 1'b1, ST_INVALID, 5));
		plan.push_back(row(OP_DELETE,   4, 32'h0));
		plan.push_back(row(OP_DELETE,   0, 32'h0));
		plan.push_back(row(OP_DUMP,     0, 32'h0));
		plan.push_back(row(OP_CLEAR,    0, 32'h0, 1'b1, ST_OK, 0));
		plan.push_back(row(OP_DUMP,     0, 32'h0, 1'b1, ST_EMPTY, 0));
		plan.push_back(row(OP_APPEND,   0, 32'h55555555));
		plan.push_back(row(OP_SEARCH,   0, 32'h55555555));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[k])
			send_request(plan[k].req, plan[k].typed, plan[k].want);
		drain();

		// fill to capacity with some repeated values, then hit the full and edge cases
		send_request(make_req(OP_CLEAR, 0, 0));
		for (i = 0; i < DEPTH; i++)
			send_request(make_req(OP_APPEND, 0, (i % 2) ? $urandom : $urandom_range(3)));
		send_request(make_req(OP_APPEND, 0, 32'h1));
		send_request(make_req(OP_INSERT, DEPTH, 32'h2));
		send_request(make_req(OP_INSERT, DEPTH + 1, 32'h3));
		send_request(make_req(OP_INSERT, 0, 32'h4));
		send_request(make_req(OP_SEARCH, 0, $urandom_range(3)));
		send_request(make_req(OP_SEARCH, 0, list_mem[DEPTH-1]));
		send_request(make_req(OP_DUMP, 0, 0));
		send_request(make_req(OP_DELETE, DEPTH - 1, 0));
		send_request(make_req(OP_DELETE, DEPTH - 1, 0));
		send_request(make_req(OP_INSERT, DEPTH - 1, 32'haaaaaaaa));
		send_request(make_req(OP_INSERT, 0, 32'h0));
		send_request(make_req(OP_DELETE, 0, 0));
		send_request(make_req(OP_DUMP, 0, 0));
		send_request(make_req(OP_CLEAR, 0, 0));

		n = 0;
		while (n < RANDOM_REQUESTS) begin
			tx_idle = !(n >= 30 && n < 60);
			rx_idle = tx_idle;
			if (n == 75)
				drain();
			c = random_req();
			send_request(c);
			if (c.opcode <= OP_DUMP)
				n++;
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		drain();
		repeat (100) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
